### hw/rtl/rrb_pkg.sv
// Shared types and codes for the request retry/backoff handshake block.
// Used by the channel interfaces and the top level; no dependencies.
package rrb_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned SPAN_W   = 20;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_RESET    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ISSUED   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PENDING  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SUCCESS  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_REFUSED  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CLOSE    = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_EXPQUERY = 3'd7;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ISSUED   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAITING  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUCCESS  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REFUSED  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TIMEDOUT = 3'd5;
  localparam logic [PHASE_W-1:0] PH_BACKOFF  = 3'd6;

  // Deny reason codes
  localparam logic [REASON_W-1:0] RSN_ALLOWED  = 3'd0;
  localparam logic [REASON_W-1:0] RSN_IN_GAP   = 3'd1;
  localparam logic [REASON_W-1:0] RSN_UNCLOSED = 3'd2;
  localparam logic [REASON_W-1:0] RSN_RESTING  = 3'd3;
  localparam logic [REASON_W-1:0] RSN_SPENT    = 3'd4;
  localparam logic [REASON_W-1:0] RSN_REFUSED  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADLINE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd3;

  // Reset values of the configuration registers
  localparam logic [SPAN_W-1:0]  MIN_GAP_RST      = 20'd1000;
  localparam logic [SPAN_W-1:0]  DEADLINE_RST     = 20'd1000;
  localparam logic [SPAN_W-1:0]  BACKOFF_RST      = 20'd2000;
  localparam logic [COUNT_W-1:0] MAX_ATTEMPTS_RST = 8'd3;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic                may_issue;
    logic [REASON_W-1:0] deny_reason;
    logic                is_expired;
    logic [COUNT_W-1:0]  attempt_count;
  } result_t;

endpackage

### hw/rtl/rrb_if.sv
// Valid/ready channel interfaces for the request retry/backoff block.
// Depends on rrb_pkg for field widths.
interface rrb_in_if;
  logic                             valid;
  logic                             ready;
  logic [rrb_pkg::ACTION_W-1:0]     action;
  logic [rrb_pkg::TIME_W-1:0]       now_ms;

  modport source (output valid, output action, output now_ms, input ready);
  modport sink   (input valid, input action, input now_ms, output ready);
endinterface

interface rrb_out_if;
  logic                             valid;
  logic                             ready;
  logic [rrb_pkg::PHASE_W-1:0]      phase;
  logic                             may_issue;
  logic [rrb_pkg::REASON_W-1:0]     deny_reason;
  logic                             is_expired;
  logic [rrb_pkg::COUNT_W-1:0]      attempt_count;

  modport source (output valid, output phase, output may_issue, output deny_reason,
                  output is_expired, output attempt_count, input ready);
  modport sink   (input valid, input phase, input may_issue, input deny_reason,
                  input is_expired, input attempt_count, output ready);
endinterface

### hw/rtl/request_retry_backoff_handshake.sv
// Top level of the request retry/backoff handshake issuer.
// Depends on rrb_pkg and the channel interfaces in rrb_if.sv.
//
//   channel  dir  payload                                             handshake
//   req      in   action, now_ms                                      valid/ready
//   rsp      out  phase, may_issue, deny_reason, is_expired, count    valid/ready
//   wr_*     in   wr_index, wr_data                                   wr_en only
//
// One event per cycle while rsp is not stalled: each event is evaluated in a
// single pass from the state registers (four 33-bit adds and compares) into a
// result register, and rsp.valid rises in the cycle after the event is accepted.
// req.ready is high whenever the result register is empty or being drained,
// so a stalled rsp holds the result and blocks only further events.
// rst is synchronous: it clears the state, the result valid and loads the
// register defaults.
module request_retry_backoff_handshake (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [rrb_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [rrb_pkg::CFG_DATA_W-1:0]    wr_data,
  rrb_in_if.sink                            req,
  rrb_out_if.source                         rsp
);

  // Configuration
  logic [rrb_pkg::SPAN_W-1:0]  min_gap_ms;
  logic [rrb_pkg::SPAN_W-1:0]  deadline_ms;
  logic [rrb_pkg::SPAN_W-1:0]  backoff_ms;
  logic [rrb_pkg::COUNT_W-1:0] max_attempts;

  // Block state
  logic [rrb_pkg::PHASE_W-1:0] phase_reg, phase_reg_next;
  logic [rrb_pkg::TIME_W-1:0]  issue_time, issue_time_next;
  logic [rrb_pkg::SUM_W-1:0]   ready_time, ready_time_next;
  logic [rrb_pkg::COUNT_W-1:0] attempts_used, attempts_used_next;

  // Result register
  rrb_pkg::result_t            result, result_next;
  logic                        result_valid;

  logic                        accept;
  logic [rrb_pkg::SUM_W-1:0]   now_ext;
  logic [rrb_pkg::SUM_W-1:0]   rest_end;
  logic [rrb_pkg::SUM_W-1:0]   old_deadline;
  logic [rrb_pkg::SUM_W-1:0]   new_deadline;
  logic [rrb_pkg::SUM_W-1:0]   new_gap_end;
  logic                        old_expired;
  logic                        new_outstanding;
  logic                        new_expired;
  logic [rrb_pkg::REASON_W-1:0] reason;

  assign req.ready = !result_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign now_ext      = {1'b0, req.now_ms};
  assign rest_end     = now_ext + {{(rrb_pkg::SUM_W-rrb_pkg::SPAN_W){1'b0}}, backoff_ms};
  assign old_deadline = {1'b0, issue_time}
                      + {{(rrb_pkg::SUM_W-rrb_pkg::SPAN_W){1'b0}}, deadline_ms};
  assign old_expired  = (phase_reg == rrb_pkg::PH_ISSUED || phase_reg == rrb_pkg::PH_WAITING)
                        && (now_ext >= old_deadline);

  // Apply the action to the state
  always_comb begin
    phase_reg_next     = phase_reg;
    issue_time_next    = issue_time;
    ready_time_next    = ready_time;
    attempts_used_next = attempts_used;
    unique case (req.action)
      rrb_pkg::ACT_RESET: begin
        phase_reg_next     = rrb_pkg::PH_IDLE;
        issue_time_next    = '0;
        ready_time_next    = '0;
        attempts_used_next = '0;
      end
      rrb_pkg::ACT_ISSUED: begin
        issue_time_next = req.now_ms;
        phase_reg_next  = rrb_pkg::PH_ISSUED;
        if (attempts_used != {rrb_pkg::COUNT_W{1'b1}}) begin
          attempts_used_next = attempts_used + 1'b1;
        end
      end
      rrb_pkg::ACT_PENDING: begin
        if (phase_reg == rrb_pkg::PH_ISSUED) begin
          phase_reg_next = rrb_pkg::PH_WAITING;
        end
      end
      rrb_pkg::ACT_SUCCESS: begin
        phase_reg_next = rrb_pkg::PH_SUCCESS;
      end
      rrb_pkg::ACT_REFUSED: begin
        phase_reg_next  = rrb_pkg::PH_REFUSED;
        ready_time_next = rest_end;
      end
      rrb_pkg::ACT_CLOSE: begin
        if (old_expired) begin
          phase_reg_next  = rrb_pkg::PH_BACKOFF;
          ready_time_next = rest_end;
        end
      end
      rrb_pkg::ACT_QUERY, rrb_pkg::ACT_EXPQUERY: begin
      end
      default: begin
      end
    endcase
  end

  // Evaluate the issue check against the updated state
  assign new_outstanding = (phase_reg_next == rrb_pkg::PH_ISSUED)
                           || (phase_reg_next == rrb_pkg::PH_WAITING);
  assign new_deadline = {1'b0, issue_time_next}
                      + {{(rrb_pkg::SUM_W-rrb_pkg::SPAN_W){1'b0}}, deadline_ms};
  assign new_gap_end  = {1'b0, issue_time_next}
                      + {{(rrb_pkg::SUM_W-rrb_pkg::SPAN_W){1'b0}}, min_gap_ms};
  assign new_expired  = new_outstanding && (now_ext >= new_deadline);

  always_comb begin
    priority if (new_outstanding) begin
      reason = (now_ext < new_gap_end) ? rrb_pkg::RSN_IN_GAP : rrb_pkg::RSN_UNCLOSED;
    end else if (phase_reg_next == rrb_pkg::PH_BACKOFF && now_ext < ready_time_next) begin
      reason = rrb_pkg::RSN_RESTING;
    end else if (attempts_used_next >= max_attempts) begin
      reason = rrb_pkg::RSN_SPENT;
    end else if (phase_reg_next == rrb_pkg::PH_REFUSED) begin
      reason = rrb_pkg::RSN_REFUSED;
    end else begin
      reason = rrb_pkg::RSN_ALLOWED;
    end
  end

  always_comb begin
    result_next.phase         = phase_reg_next;
    result_next.may_issue     = (reason == rrb_pkg::RSN_ALLOWED);
    result_next.deny_reason   = reason;
    result_next.is_expired    = new_expired;
    result_next.attempt_count = attempts_used_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ms   <= rrb_pkg::MIN_GAP_RST;
      deadline_ms  <= rrb_pkg::DEADLINE_RST;
      backoff_ms   <= rrb_pkg::BACKOFF_RST;
      max_attempts <= rrb_pkg::MAX_ATTEMPTS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        rrb_pkg::REG_MIN_GAP:      min_gap_ms   <= wr_data[rrb_pkg::SPAN_W-1:0];
        rrb_pkg::REG_DEADLINE:     deadline_ms  <= wr_data[rrb_pkg::SPAN_W-1:0];
        rrb_pkg::REG_BACKOFF:      backoff_ms   <= wr_data[rrb_pkg::SPAN_W-1:0];
        rrb_pkg::REG_MAX_ATTEMPTS: max_attempts <= wr_data[rrb_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= rrb_pkg::PH_IDLE;
      issue_time    <= '0;
      ready_time    <= '0;
      attempts_used <= '0;
    end else if (accept) begin
      phase_reg     <= phase_reg_next;
      issue_time    <= issue_time_next;
      ready_time    <= ready_time_next;
      attempts_used <= attempts_used_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (rsp.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign rsp.valid         = result_valid;
  assign rsp.phase         = result.phase;
  assign rsp.may_issue     = result.may_issue;
  assign rsp.deny_reason   = result.deny_reason;
  assign rsp.is_expired    = result.is_expired;
  assign rsp.attempt_count = result.attempt_count;

endmodule
